### rtl/rcpwm_pkg.sv
package rcpwm_pkg;

    localparam int NUM_CH = 4;
    localparam int CH_W   = 2;
    localparam int VAL_W  = 16;
    localparam int CNT_W  = 2;
    localparam int PER_W  = 17;
    localparam int CFG_W  = 17;
    localparam int QUOT_W = 10;

    localparam logic [CH_W-1:0]  THROTTLE_CH = 2'd3;
    localparam logic [CNT_W-1:0] LOST_LIMIT  = 2'd2;

    // floor(x / 100) for any 16-bit x: (x * 83887) >> 23
    localparam logic [16:0]      FS_RECIP = 17'd83887;
    localparam int               FS_SHIFT = 23;

    localparam logic [PER_W-1:0] PERIOD_RST  = 17'd20000;
    localparam logic [VAL_W-1:0] MIN_RST     = 16'd1000;
    localparam logic [VAL_W-1:0] MAX_RST     = 16'd2000;
    localparam logic [VAL_W-1:0] NEUTRAL_RST = 16'd1500;

    localparam logic FUNC_TICK = 1'b0;
    localparam logic FUNC_EDGE = 1'b1;

    typedef enum logic [1:0] {
        CFG_PERIOD    = 2'd0,
        CFG_PULSE_MIN = 2'd1,
        CFG_PULSE_MAX = 2'd2,
        CFG_NEUTRAL   = 2'd3
    } cfg_index_t;

    typedef struct packed {
        logic [PER_W-1:0] period_counts;
        logic [VAL_W-1:0] pulse_min;
        logic [VAL_W-1:0] pulse_max;
        logic [VAL_W-1:0] neutral_value;
    } cfg_t;

    typedef struct packed {
        logic [VAL_W-1:0]  pitch_value;
        logic [VAL_W-1:0]  roll_value;
        logic [VAL_W-1:0]  yaw_value;
        logic [VAL_W-1:0]  throttle_value;
        logic [NUM_CH-1:0] lost_mask;
    } out_item_t;

    typedef struct packed {
        logic      valid;
        out_item_t item;
    } push_t;

endpackage

### rtl/rcpwm_in_if.sv
interface rcpwm_in_if import rcpwm_pkg::*; ();
    logic             valid;
    logic             ready;
    logic             func;
    logic [CH_W-1:0]  channel;
    logic             edge_rising;
    logic [VAL_W-1:0] capture_time;

    modport source (output valid, func, channel, edge_rising, capture_time, input ready);
    modport sink   (input valid, func, channel, edge_rising, capture_time, output ready);
    modport monitor (input valid, ready, func, channel, edge_rising, capture_time);
endinterface

### rtl/rcpwm_out_if.sv
interface rcpwm_out_if import rcpwm_pkg::*; ();
    logic              valid;
    logic              ready;
    logic [VAL_W-1:0]  pitch_value;
    logic [VAL_W-1:0]  roll_value;
    logic [VAL_W-1:0]  yaw_value;
    logic [VAL_W-1:0]  throttle_value;
    logic [NUM_CH-1:0] lost_mask;

    modport source (output valid, pitch_value, roll_value, yaw_value, throttle_value,
                    lost_mask, input ready);
    modport sink   (input valid, pitch_value, roll_value, yaw_value, throttle_value,
                    lost_mask, output ready);
    modport monitor (input valid, ready, pitch_value, roll_value, yaw_value,
                     throttle_value, lost_mask);
endinterface

### rtl/rcpwm_core.sv
module rcpwm_core import rcpwm_pkg::*; #(
    parameter int CAPTURE_BITS = 16
) (
    input  logic        clk,
    input  logic        rst_n,
    rcpwm_in_if.sink    events,
    input  cfg_t        cfg,
    input  logic        space,
    output push_t       push
);

    localparam logic [VAL_W-1:0] CAP_MASK = (CAPTURE_BITS >= VAL_W) ? {VAL_W{1'b1}} :
        VAL_W'((64'd1 << CAPTURE_BITS) - 64'd1);

    // input register
    logic             s1_valid_reg;
    logic             s1_func_reg;
    logic [CH_W-1:0]  s1_channel_reg;
    logic             s1_rising_reg;
    logic [VAL_W-1:0] s1_cap_reg;

    // channel state
    logic [VAL_W-1:0] rise_reg  [NUM_CH];
    logic [VAL_W-1:0] value_reg [NUM_CH];
    logic [CNT_W-1:0] miss_reg  [NUM_CH];
    logic [VAL_W-1:0] span_reg;

    logic [VAL_W-1:0] rise_next  [NUM_CH];
    logic [VAL_W-1:0] value_next [NUM_CH];
    logic [CNT_W-1:0] miss_next  [NUM_CH];
    logic [VAL_W-1:0] span_next;

    logic             advance;
    logic [VAL_W-1:0] cap;
    logic [VAL_W-1:0] rise;
    logic             wrap;
    logic signed [18:0] diff;
    logic signed [18:0] width;
    logic [VAL_W-1:0] clamped;

    logic [NUM_CH-1:0]   lost;
    logic [1:0]          n_lost;
    logic [32:0]         prod;
    logic [QUOT_W-1:0]   quot;
    logic [11:0]         amount_n;
    logic [VAL_W-1:0]    thr_mid;
    logic [VAL_W-1:0]    thr_fin;
    logic [VAL_W-1:0]    span_val;

    function automatic logic [VAL_W-1:0] floor_sub(input logic [VAL_W-1:0] value,
                                                   input logic [11:0] amount,
                                                   input logic [VAL_W-1:0] floor_v);
        logic signed [17:0] d;
        d = $signed({2'b00, value}) - $signed({6'b0, amount});
        return (d < $signed({2'b00, floor_v})) ? floor_v : d[VAL_W-1:0];
    endfunction

    assign advance      = s1_valid_reg && space;
    assign events.ready = !s1_valid_reg || space;

    // capture the transaction
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg <= 1'b0;
        end
        else if (events.ready)
        begin
            s1_valid_reg <= events.valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (events.ready && events.valid)
        begin
            s1_func_reg    <= events.func;
            s1_channel_reg <= events.channel;
            s1_rising_reg  <= events.edge_rising;
            s1_cap_reg     <= events.capture_time;
        end
    end

    // pulse width from a falling edge, wrapped and clamped
    assign cap  = s1_cap_reg & CAP_MASK;
    assign rise = rise_reg[s1_channel_reg];
    assign wrap = (cap <= rise);
    assign diff = $signed({3'b000, cap}) - $signed({3'b000, rise});
    assign width = wrap ? diff + $signed({2'b00, cfg.period_counts}) : diff;

    always_comb
    begin
        priority if (width > $signed({3'b000, cfg.pulse_max}))
            clamped = cfg.pulse_max;
        else if (width < $signed({3'b000, cfg.pulse_min}))
            clamped = cfg.pulse_min;
        else
            clamped = width[VAL_W-1:0];
    end

    // failsafe ramp: every lost channel takes span/100 off throttle
    always_comb
    begin
        for (int i = 0; i < NUM_CH; i++)
        begin
            lost[i] = (miss_reg[i] == LOST_LIMIT);
        end
    end

    assign n_lost   = {1'b0, lost[0]} + {1'b0, lost[1]} + {1'b0, lost[2]};
    assign prod     = span_reg * FS_RECIP;
    assign quot     = prod[32:FS_SHIFT];
    assign amount_n = 12'(n_lost) * 12'(quot);
    assign thr_mid  = (n_lost != 2'd0) ?
                      floor_sub(value_reg[THROTTLE_CH], amount_n, cfg.pulse_min) :
                      value_reg[THROTTLE_CH];
    assign thr_fin  = lost[THROTTLE_CH] ?
                      floor_sub(thr_mid, 12'(quot), cfg.pulse_min) : thr_mid;
    assign span_val = (thr_mid > cfg.pulse_min) ? thr_mid - cfg.pulse_min : '0;

    // next channel state
    always_comb
    begin
        rise_next  = rise_reg;
        value_next = value_reg;
        miss_next  = miss_reg;
        span_next  = span_reg;
        if (s1_func_reg == FUNC_EDGE)
        begin
            if (s1_rising_reg)
            begin
                rise_next[s1_channel_reg] = cap;
            end
            else
            begin
                value_next[s1_channel_reg] = clamped;
                miss_next[s1_channel_reg]  = '0;
            end
        end
        else
        begin
            for (int i = 0; i < NUM_CH; i++)
            begin
                miss_next[i] = lost[i] ? LOST_LIMIT : miss_reg[i] + 2'd1;
            end
            if (lost != '0)
            begin
                for (int k = 0; k < NUM_CH - 1; k++)
                begin
                    value_next[k] = cfg.neutral_value;
                end
            end
            value_next[THROTTLE_CH] = thr_fin;
            if (!lost[THROTTLE_CH])
            begin
                span_next = span_val;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < NUM_CH; i++)
            begin
                rise_reg[i]  <= '0;
                value_reg[i] <= (i == int'(THROTTLE_CH)) ? MIN_RST : NEUTRAL_RST;
                miss_reg[i]  <= '0;
            end
            span_reg <= '0;
        end
        else if (advance)
        begin
            rise_reg  <= rise_next;
            value_reg <= value_next;
            miss_reg  <= miss_next;
            span_reg  <= span_next;
        end
    end

    // result for the queue
    always_comb
    begin
        push.valid               = advance;
        push.item.pitch_value    = value_next[0];
        push.item.roll_value     = value_next[1];
        push.item.yaw_value      = value_next[2];
        push.item.throttle_value = value_next[THROTTLE_CH];
        for (int i = 0; i < NUM_CH; i++)
        begin
            push.item.lost_mask[i] = (miss_next[i] == LOST_LIMIT);
        end
    end

endmodule

### rtl/rcpwm_out_queue.sv
module rcpwm_out_queue import rcpwm_pkg::*; (
    input  logic        clk,
    input  logic        rst_n,
    input  push_t       push,
    output logic        space,
    rcpwm_out_if.source results
);

    out_item_t  entry_reg [2];
    logic       head_reg;
    logic       tail_reg;
    logic [1:0] count_reg;
    logic [1:0] count_next;
    logic       pop;

    assign space = (count_reg != 2'd2);
    assign pop   = results.valid && results.ready;

    assign results.valid          = (count_reg != 2'd0);
    assign results.pitch_value    = entry_reg[head_reg].pitch_value;
    assign results.roll_value     = entry_reg[head_reg].roll_value;
    assign results.yaw_value      = entry_reg[head_reg].yaw_value;
    assign results.throttle_value = entry_reg[head_reg].throttle_value;
    assign results.lost_mask      = entry_reg[head_reg].lost_mask;

    always_comb
    begin
        count_next = count_reg;
        if (push.valid && !pop)
            count_next = count_reg + 2'd1;
        else if (pop && !push.valid)
            count_next = count_reg - 2'd1;
    end

    // advance pointers and count
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            head_reg  <= 1'b0;
            tail_reg  <= 1'b0;
            count_reg <= 2'd0;
        end
        else
        begin
            count_reg <= count_next;
            if (push.valid)
                tail_reg <= !tail_reg;
            if (pop)
                head_reg <= !head_reg;
        end
    end

    // hold the result until the sink takes it
    always_ff @(posedge clk)
    begin
        if (push.valid)
        begin
            entry_reg[tail_reg] <= push.item;
        end
    end

endmodule

### rtl/rc_pwm_pulse_decoder_failsafe.sv
// Four-channel RC pulse decoder (pitch, roll, yaw, throttle) with loss-of-signal
// failsafe. Each transaction on events is either a period tick (func 0) or a
// timestamped edge on one channel (func 1); every one yields exactly one result
// transaction with all four channel values and the lost mask after that event.
// The block takes one event per clock while the output queue has space: each
// event is registered on entry, then updates the channel state and pushes its
// result into the two-entry output queue once it has space. With the result
// sink stalled the block holds up to three events, two finished results in the
// queue and one in the input register, before events.ready drops. Throttle
// ramp-down per lost channel is floor(span/100), span being the throttle lead
// over pulse_min remembered at the last tick on which throttle was still alive.
// Configuration writes are taken at any time but should be made while idle.
module rc_pwm_pulse_decoder_failsafe import rcpwm_pkg::*; #(
    parameter int CAPTURE_BITS = 16
) (
    input  logic             clk,
    input  logic             rst_n,
    rcpwm_in_if.sink         events,
    rcpwm_out_if.source      results,
    input  logic             cfg_we,
    input  logic [1:0]       cfg_index,
    input  logic [CFG_W-1:0] cfg_data
);

    cfg_t  cfg_reg;
    push_t push;
    logic  space;

    // configuration registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.period_counts <= PERIOD_RST;
            cfg_reg.pulse_min     <= MIN_RST;
            cfg_reg.pulse_max     <= MAX_RST;
            cfg_reg.neutral_value <= NEUTRAL_RST;
        end
        else if (cfg_we)
        begin
            unique case (cfg_index_t'(cfg_index))
                CFG_PERIOD:    cfg_reg.period_counts <= cfg_data;
                CFG_PULSE_MIN: cfg_reg.pulse_min     <= cfg_data[VAL_W-1:0];
                CFG_PULSE_MAX: cfg_reg.pulse_max     <= cfg_data[VAL_W-1:0];
                CFG_NEUTRAL:   cfg_reg.neutral_value <= cfg_data[VAL_W-1:0];
                default:       cfg_reg <= cfg_reg;
            endcase
        end
    end

    rcpwm_core #(
        .CAPTURE_BITS (CAPTURE_BITS)
    ) u_core (
        .clk    (clk),
        .rst_n  (rst_n),
        .events (events),
        .cfg    (cfg_reg),
        .space  (space),
        .push   (push)
    );

    rcpwm_out_queue u_queue (
        .clk     (clk),
        .rst_n   (rst_n),
        .push    (push),
        .space   (space),
        .results (results)
    );

endmodule

### rtl/rcpwm_checker.sv
module rcpwm_checker import rcpwm_pkg::*; (
    input logic              clk,
    input logic              rst_n,
    input logic              in_valid,
    input logic              in_ready,
    input logic              out_valid,
    input logic              out_ready,
    input logic [VAL_W-1:0]  pitch_value,
    input logic [VAL_W-1:0]  roll_value,
    input logic [VAL_W-1:0]  yaw_value,
    input logic [VAL_W-1:0]  throttle_value,
    input logic [NUM_CH-1:0] lost_mask
);

    logic [2:0] pending_reg;
    logic       in_acc;
    logic       out_acc;

    assign in_acc  = in_valid && in_ready;
    assign out_acc = out_valid && out_ready;

    // track transactions in flight
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            pending_reg <= 3'd0;
        else if (in_acc && !out_acc)
            pending_reg <= pending_reg + 3'd1;
        else if (out_acc && !in_acc)
            pending_reg <= pending_reg - 3'd1;
    end

    a_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid &&
        $stable(pitch_value) && $stable(roll_value) &&
        $stable(yaw_value) && $stable(throttle_value) &&
        $stable(lost_mask))
        else $error("result changed while stalled");

    a_no_invent: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> pending_reg != 3'd0)
        else $error("result without a pending event");

    a_bounded: assert property (@(posedge clk) disable iff (!rst_n)
        pending_reg <= 3'd3)
        else $error("more events in flight than storage");

    a_idle_ready: assert property (@(posedge clk) disable iff (!rst_n)
        pending_reg == 3'd0 |-> in_ready)
        else $error("empty block refuses events");

endmodule

bind rc_pwm_pulse_decoder_failsafe rcpwm_checker u_checker (
    .clk            (clk),
    .rst_n          (rst_n),
    .in_valid       (events.valid),
    .in_ready       (events.ready),
    .out_valid      (results.valid),
    .out_ready      (results.ready),
    .pitch_value    (results.pitch_value),
    .roll_value     (results.roll_value),
    .yaw_value      (results.yaw_value),
    .throttle_value (results.throttle_value),
    .lost_mask      (results.lost_mask)
);

### tb/tb.sv
module tb;
    timeunit 1ns;
    timeprecision 1ps;

    import rcpwm_pkg::*;

    localparam int FAILSAFE_DIV = 100;

    // Track channel widths, missed periods and expected result transactions
    class pulse_scoreboard;
        logic [PER_W-1:0] period_counts;
        logic [VAL_W-1:0] pulse_min;
        logic [VAL_W-1:0] pulse_max;
        logic [VAL_W-1:0] neutral_value;
        logic [VAL_W-1:0] rise_at [NUM_CH];
        logic [VAL_W-1:0] level [NUM_CH];
        logic [CNT_W-1:0] missed [NUM_CH];
        logic [VAL_W-1:0] throttle_span;
        out_item_t        pending_frames [$];
        int unsigned      mismatches;
        int unsigned      checked;
        int unsigned      ticks;
        int unsigned      edges;
        int unsigned      failsafe_hits;

        function new();
            period_counts = PERIOD_RST;
            pulse_min     = MIN_RST;
            pulse_max     = MAX_RST;
            neutral_value = NEUTRAL_RST;
            for (int i = 0; i < NUM_CH; i++)
            begin
                rise_at[i] = '0;
                level[i]   = NEUTRAL_RST;
                missed[i]  = '0;
            end
            level[THROTTLE_CH] = MIN_RST;
            throttle_span      = '0;
        endfunction

        function void set_reg(cfg_index_t idx, logic [CFG_W-1:0] data);
            case (idx)
                CFG_PERIOD:    period_counts = data[PER_W-1:0];
                CFG_PULSE_MIN: pulse_min     = data[VAL_W-1:0];
                CFG_PULSE_MAX: pulse_max     = data[VAL_W-1:0];
                CFG_NEUTRAL:   neutral_value = data[VAL_W-1:0];
                default: ;
            endcase
        endfunction

        function int unsigned pending_count();
            return pending_frames.size();
        endfunction

        // Advance the channel state by one event and queue the resulting frame
        function void note_event(logic func, logic [CH_W-1:0] ch, logic rising,
                                 logic [VAL_W-1:0] cap);
            out_item_t frame;
            longint    width, c_now, r_then, per, lo, hi, thr, drop;
            lo  = longint'(pulse_min);
            hi  = longint'(pulse_max);
            per = longint'(period_counts);
            if (func == FUNC_EDGE)
            begin
                edges++;
                if (rising)
                    rise_at[ch] = cap;
                else
                begin
                    c_now  = longint'(cap);
                    r_then = longint'(rise_at[ch]);
                    // Add the period when the counter wrapped, sign kept
                    if (c_now > r_then)
                        width = c_now - r_then;
                    else
                        width = per + c_now - r_then;
                    if (width > hi)
                        width = hi;
                    else if (width < lo)
                        width = lo;
                    level[ch]  = width[VAL_W-1:0];
                    missed[ch] = '0;
                end
            end
            else
            begin
                ticks++;
                // Visit the channels in order; a lost one ramps throttle down
                for (int i = 0; i < NUM_CH; i++)
                begin
                    if (missed[i] == LOST_LIMIT)
                    begin
                        failsafe_hits++;
                        drop = longint'(throttle_span) / FAILSAFE_DIV;
                        thr  = longint'(level[THROTTLE_CH]);
                        thr  = thr - drop;
                        if (thr < lo)
                            thr = lo;
                        level[THROTTLE_CH] = thr[VAL_W-1:0];
                        for (int k = 0; k < NUM_CH - 1; k++)
                            level[k] = neutral_value;
                    end
                    else
                    begin
                        missed[i] = missed[i] + 1'b1;
                        if (i == THROTTLE_CH)
                            throttle_span = (level[THROTTLE_CH] > pulse_min) ?
                                            level[THROTTLE_CH] - pulse_min : '0;
                    end
                end
            end
            frame.pitch_value    = level[0];
            frame.roll_value     = level[1];
            frame.yaw_value      = level[2];
            frame.throttle_value = level[THROTTLE_CH];
            for (int i = 0; i < NUM_CH; i++)
                frame.lost_mask[i] = (missed[i] == LOST_LIMIT);
            pending_frames.push_back(frame);
        endfunction

        function void compare_field(string name, logic [VAL_W-1:0] want,
                                    logic [VAL_W-1:0] got);
            if (got !== want)
            begin
                if (mismatches < 10)
                    $display("result %0d: %s expected %0d, got %0d",
                             checked, name, want, got);
                mismatches++;
            end
        endfunction

        // Compare one result transaction against the oldest queued frame
        function void check_frame(out_item_t got);
            out_item_t want;
            if (pending_frames.size() == 0)
            begin
                if (mismatches < 10)
                    $display("result %0d: unexpected transaction", checked);
                mismatches++;
            end
            else
            begin
                want = pending_frames.pop_front();
                compare_field("pitch", want.pitch_value, got.pitch_value);
                compare_field("roll", want.roll_value, got.roll_value);
                compare_field("yaw", want.yaw_value, got.yaw_value);
                compare_field("throttle", want.throttle_value, got.throttle_value);
                compare_field("lost_mask", VAL_W'(want.lost_mask), VAL_W'(got.lost_mask));
            end
            checked++;
        endfunction
    endclass

    logic             clk = 1'b0;
    logic             rst_n;
    logic             cfg_we;
    cfg_index_t       cfg_index;
    logic [CFG_W-1:0] cfg_data;

    rcpwm_in_if  ev_if ();
    rcpwm_out_if res_if ();

    pulse_scoreboard board;
    int unsigned     idle_pct;
    int unsigned     sent;
    int unsigned     settings_used;

    rc_pwm_pulse_decoder_failsafe u_top (
        .clk       (clk),
        .rst_n     (rst_n),
        .events    (ev_if),
        .results   (res_if),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    // Sample both channels at the rising edge
    always @(posedge clk)
    begin : monitor
        out_item_t got;
        if (rst_n)
        begin
            if (res_if.valid && res_if.ready)
            begin
                got.pitch_value    = res_if.pitch_value;
                got.roll_value     = res_if.roll_value;
                got.yaw_value      = res_if.yaw_value;
                got.throttle_value = res_if.throttle_value;
                got.lost_mask      = res_if.lost_mask;
                board.check_frame(got);
            end
            if (ev_if.valid && ev_if.ready)
                board.note_event(ev_if.func, ev_if.channel, ev_if.edge_rising,
                                 ev_if.capture_time);
        end
    end

    // Stall the result side in random bursts
    initial
    begin : result_sink
        int unsigned hold;
        res_if.ready = 1'b0;
        @(posedge rst_n);
        forever
        begin
            @(negedge clk);
            if (idle_pct != 0 && $urandom_range(0, 99) < idle_pct)
            begin
                res_if.ready <= 1'b0;
                hold = $urandom_range(1, 13);
                repeat (hold - 1) @(negedge clk);
            end
            else
                res_if.ready <= 1'b1;
        end
    end

    task automatic send_event(input logic func, input logic [CH_W-1:0] ch,
                              input logic rising, input logic [VAL_W-1:0] cap);
        if (idle_pct != 0 && $urandom_range(0, 99) < idle_pct)
        begin
            ev_if.valid <= 1'b0;
            repeat ($urandom_range(1, 13)) @(negedge clk);
        end
        ev_if.valid        <= 1'b1;
        ev_if.func         <= func;
        ev_if.channel      <= ch;
        ev_if.edge_rising  <= rising;
        ev_if.capture_time <= cap;
        @(posedge clk);
        while (!ev_if.ready)
            @(posedge clk);
        @(negedge clk);
        sent++;
    endtask

    // Hold off new events until every queued frame has come back
    task automatic wait_drained();
        ev_if.valid <= 1'b0;
        while (board.pending_count() != 0)
            @(negedge clk);
        repeat (4) @(negedge clk);
    endtask

    task automatic write_reg(input cfg_index_t idx, input logic [CFG_W-1:0] data);
        cfg_we    <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= data;
        board.set_reg(idx, data);
        @(negedge clk);
    endtask

    task automatic apply_settings(input logic [PER_W-1:0] period,
                                  input logic [VAL_W-1:0] lo, hi, neutral);
        write_reg(CFG_PERIOD, CFG_W'(period));
        write_reg(CFG_PULSE_MIN, CFG_W'(lo));
        write_reg(CFG_PULSE_MAX, CFG_W'(hi));
        write_reg(CFG_NEUTRAL, CFG_W'(neutral));
        cfg_we <= 1'b0;
        settings_used++;
    endtask

    // Mostly rise/fall pairs on live channels, plus ticks and stray edges
    task automatic run_random(input int unsigned n_items, input logic [NUM_CH-1:0] alive);
        int unsigned     start;
        int unsigned     pick;
        logic [CH_W-1:0] ch;
        longint          per, lo, hi, r_at, width, c_at;
        start = sent;
        while (sent - start < n_items)
        begin
            pick = $urandom_range(0, 99);
            ch   = CH_W'($urandom_range(0, NUM_CH - 1));
            if (pick < 25)
                send_event(FUNC_TICK, CH_W'($urandom), 1'($urandom), VAL_W'($urandom));
            else if (pick < 85)
            begin
                if (!alive[ch] && $urandom_range(0, 3) != 0)
                    continue;
                per = longint'(board.period_counts);
                lo  = longint'((board.pulse_min < board.pulse_max) ?
                               board.pulse_min : board.pulse_max);
                hi  = longint'((board.pulse_min < board.pulse_max) ?
                               board.pulse_max : board.pulse_min);
                r_at = longint'($urandom_range(0, 32'(per - 1)));
                if ($urandom_range(0, 9) < 7)
                    width = longint'($urandom_range(32'((lo > 64) ? lo - 64 : 0),
                                                    32'(hi + 64)));
                else
                    width = longint'($urandom_range(0, 32'(per)));
                c_at = (r_at + width) % per;
                send_event(FUNC_EDGE, ch, 1'b1, VAL_W'(r_at));
                send_event(FUNC_EDGE, ch, 1'b0, VAL_W'(c_at));
            end
            else
                send_event(FUNC_EDGE, ch, 1'($urandom), VAL_W'($urandom));
            if ($urandom_range(0, 199) == 0)
                wait_drained();
        end
    endtask

    initial
    begin
        board = new();
        rst_n              = 1'b0;
        ev_if.valid        = 1'b0;
        ev_if.func         = FUNC_TICK;
        ev_if.channel      = '0;
        ev_if.edge_rising  = 1'b0;
        ev_if.capture_time = '0;
        cfg_we             = 1'b0;
        cfg_index          = CFG_PERIOD;
        cfg_data           = '0;
        idle_pct           = 0;
        sent               = 0;
        settings_used      = 1;
        repeat (5) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        // Directed: tick fields ignored, plain widths, wraps, clamps, failsafe ramp
        send_event(FUNC_TICK, 2'd3, 1'b1, 16'hFFFF);
        send_event(FUNC_EDGE, 2'd0, 1'b1, 16'd100);
        send_event(FUNC_EDGE, 2'd0, 1'b0, 16'd1600);
        send_event(FUNC_EDGE, 2'd1, 1'b1, 16'hFFFF);
        send_event(FUNC_EDGE, 2'd1, 1'b0, 16'h0000);
        send_event(FUNC_EDGE, 2'd2, 1'b1, 16'd5000);
        send_event(FUNC_EDGE, 2'd2, 1'b0, 16'd5000);
        send_event(FUNC_EDGE, THROTTLE_CH, 1'b1, 16'd0);
        send_event(FUNC_EDGE, THROTTLE_CH, 1'b0, 16'd1900);
        send_event(FUNC_EDGE, 2'd0, 1'b1, 16'd19000);
        send_event(FUNC_EDGE, 2'd0, 1'b0, 16'd500);
        send_event(FUNC_EDGE, 2'd0, 1'b0, 16'hFFFF);
        repeat (4) send_event(FUNC_TICK, 2'd0, 1'b0, 16'h0000);
        send_event(FUNC_EDGE, THROTTLE_CH, 1'b1, 16'd0);
        send_event(FUNC_EDGE, THROTTLE_CH, 1'b0, 16'd5);
        send_event(FUNC_TICK, 2'd2, 1'b0, 16'h5555);
        send_event(FUNC_EDGE, 2'd1, 1'b1, 16'h5555);
        send_event(FUNC_EDGE, 2'd1, 1'b0, 16'hAAAA);
        send_event(FUNC_TICK, 2'd1, 1'b1, 16'hAAAA);

        // Random phases, each under its own register setting
        wait_drained();
        apply_settings(17'd20000, 16'd1000, 16'd2000, 16'd1500);
        run_random(200, 4'b1111);
        wait_drained();
        idle_pct = 30;
        apply_settings(17'h10000, 16'd0, 16'hFFFF, 16'hFFFF);
        run_random(200, 4'b0111);
        wait_drained();
        idle_pct = 15;
        apply_settings(17'd1, 16'hFFFF, 16'd0, 16'd0);
        run_random(150, 4'b1010);
        wait_drained();
        apply_settings(17'd50000, 16'd3000, 16'd1200, 16'd777);
        run_random(200, 4'b0101);
        wait_drained();
        idle_pct = 25;
        apply_settings(PER_W'($urandom_range(1, 65536)), VAL_W'($urandom_range(0, 3000)),
                       VAL_W'($urandom_range(500, 4000)), VAL_W'($urandom));
        run_random(200, NUM_CH'($urandom));

        // Last stretch at full rate on both sides
        wait_drained();
        idle_pct = 0;
        apply_settings(17'd20000, 16'd900, 16'd2100, 16'd1500);
        run_random(250, 4'b1111);

        wait_drained();
        repeat (10) @(negedge clk);
        $display("covered %0d events (%0d ticks, %0d edges, %0d failsafe steps)",
                 sent, board.ticks, board.edges, board.failsafe_hits);
        $display("%0d results checked across %0d register settings, %0d mismatches",
                 board.checked, settings_used, board.mismatches);
        if (board.mismatches == 0 && board.pending_count() == 0)
            $display("rc_pwm_pulse_decoder_failsafe: match");
        else
            $display("rc_pwm_pulse_decoder_failsafe: mismatch");
        $finish;
    end

    // Bound the run in case a transaction never completes
    initial
    begin
        #5_000_000;
        $display("timeout with %0d results outstanding", board.pending_count());
        $display("rc_pwm_pulse_decoder_failsafe: mismatch");
        $finish;
    end

endmodule
